>>> rtl/hgbb_pkg.sv
// Shared types and constants of the hit grid bucket builder.
package hgbb_pkg;

  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_BUILD     = 2'd1,
    OP_READ_SLOT = 2'd2,
    OP_READ_CELL = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // phi minimum is -pi; Q4.12
  localparam int PI_Q     = 12868;
  localparam int TWO_PI_Q = 25736;

  localparam int BINS_MAX = 62;

  localparam logic [2:0] REG_PHI_BINS   = 3'd0;
  localparam logic [2:0] REG_T_BINS     = 3'd1;
  localparam logic [2:0] REG_T_MINIMUM  = 3'd2;
  localparam logic [2:0] REG_T_INV      = 3'd3;
  localparam logic [2:0] REG_PHI_INV    = 3'd4;
  localparam logic [2:0] REG_PHI_BW     = 3'd5;
  localparam logic [2:0] REG_CLONE      = 3'd6;

  typedef struct packed {
    op_t                op;
    logic [15:0]        hit_id;
    logic signed [15:0] hit_phi;
    logic signed [15:0] hit_t;
    logic [12:0]        read_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_id;
    logic signed [15:0] out_phi;
    logic signed [15:0] out_t;
    logic [12:0]        cell_first;
    logic [12:0]        cell_count;
    logic [13:0]        sorted_total;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [5:0]         phi_bins;
    logic [5:0]         t_bins;
    logic signed [15:0] t_minimum;
    logic [23:0]        t_inverse_width;
    logic [23:0]        phi_inverse_width;
    logic [14:0]        phi_bin_width;
    logic               clone_enable;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EMIT,
    S_RDS,
    S_RDC,
    S_SETUP,
    S_LIM,
    S_CLRS,
    S_CLRC,
    S_HRD,
    S_HPHI,
    S_HT,
    S_HCELL,
    S_CNT_RD,
    S_CNT_WR,
    S_CC_RD,
    S_CC_W1,
    S_CC_W2,
    S_PF_RD,
    S_PF_WR,
    S_SC_RD,
    S_SC_WR,
    S_CP_A,
    S_CP_B,
    S_CP_C,
    S_CP_LOOP,
    S_CP_W,
    S_BDONE
  } state_t;

endpackage

>>> rtl/hit_grid_bucket_builder_core.sv
// Top level of the hit grid bucket builder: sequencer, stores and result register.
//
// Hits are loaded one beat at a time into a raw store; a build beat bins every
// stored hit into a phi/t grid with one border column and row on each side,
// counts hits per cell, turns the counts into first slots by a running sum and
// scatters the hits into a sorted store; with clone mode on, the border phi
// columns get copies of the opposite interior column, phi wrapped across the
// seam. Read beats return a sorted hit or a cell's first slot and count. One
// beat is worked at a time and in_stall is high meanwhile; the result sits in
// an output register, so the next beat is taken while it waits. A build opens
// with a clearing pass over the whole sorted store and one over the cell
// counts; each hit is binned twice through the one shared 16x24 bin
// multiplier, and every store is a single-read-port RAM.
module hit_grid_bucket_builder_core #(
  parameter int MAX_HITS     = 4096,
  parameter int MAX_CELLS    = 4096,
  parameter int SORTED_DEPTH = 8192
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hgbb_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hgbb_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int HAW    = $clog2(MAX_HITS);
  localparam int HCW    = $clog2(MAX_HITS + 1);
  localparam int CAW    = $clog2(MAX_CELLS);
  localparam int CCW    = $clog2(MAX_CELLS + 1);
  localparam int SAW    = $clog2(SORTED_DEPTH);
  localparam int SCW    = $clog2(SORTED_DEPTH + 1);
  localparam int NW     = (HCW > SCW) ? HCW : SCW;   // per-cell count width
  localparam int KW     = (SCW > CCW) ? SCW : CCW;   // sweep counter width
  localparam int PE_MAX = MAX_CELLS / 3 - 2;         // keeps 3 rows fitting

  hgbb_pkg::cfg_t      cfg;
  hgbb_pkg::state_t    state_r, state_nxt;
  hgbb_pkg::out_item_t res_r, out_data_r;
  hgbb_pkg::out_item_t res_init, emit_item;

  logic            out_valid_r;
  logic            in_accept, emit_ok;

  logic [HCW-1:0]  raw_count_r;
  logic [SCW-1:0]  sorted_count_r;
  logic [CCW-1:0]  built_cells_r;

  logic [5:0]      pe_r, te_r, ip_r;
  logic [6:0]      w_r, hgt_r, row_r;
  logic [CCW-1:0]  cells_r, base_r;
  logic [HCW-1:0]  h_r;
  logic [KW-1:0]   cnt_r;
  logic            scat_r, side_r, idx_ok_r;
  logic [47:0]     hit_r;
  logic [CAW-1:0]  cell_r;
  logic [SCW-1:0]  run_r, sstart_r, dstart_r;
  logic [NW-1:0]   fsrc_r, n_r, i_r;

  // store ports
  logic            raw_we, cap_we, start_we, fill_we, sort_we;
  logic [HAW-1:0]  raw_raddr;
  logic [47:0]     raw_wdata, raw_rd;
  logic [CAW-1:0]  cap_waddr, cap_raddr, start_waddr, start_raddr;
  logic [CAW-1:0]  fill_waddr, fill_raddr;
  logic [NW-1:0]   cap_wdata, cap_rd, fill_wdata, fill_rd;
  logic [SCW-1:0]  start_wdata, start_rd;
  logic [SAW-1:0]  sort_waddr, sort_raddr;
  logic [47:0]     sort_wdata, sort_rd;

  // bin unit
  logic signed [17:0] bin_diff;
  logic [23:0]        bin_inv;
  logic [5:0]         bin_nb, bin_q;

  // helper arithmetic, widened to 32 bits and cut down at use
  logic [31:0] idx32, cnt32, base32, w32, h32, run32;
  logic [31:0] lim_prod, cell32, cap32, fill32, start32, room32, clip32;
  logic [31:0] scd32, cps32, cpd32, left_src32, right_src32, right_dst32;
  logic [31:0] src32, dst32;
  logic [5:0]  pe_clamp, te_clamp, pe_lim;
  logic        h_last, row_last, clrs_last, cells_last;
  logic        slot_ok, cell_ok, sc_put, cp_go;
  logic [NW-1:0] n_min;
  logic signed [17:0] cp_phi, cp_phi_w, pbw18;

  hgbb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hgbb_bin_unit u_bin (
    .clk   (clk),
    .diff  (bin_diff),
    .inv   (bin_inv),
    .nb    (bin_nb),
    .bin_q (bin_q)
  );

  hgbb_ram #(.WIDTH(48), .DEPTH(MAX_HITS)) u_raw (
    .clk(clk), .we(raw_we), .waddr(raw_count_r[HAW-1:0]), .wdata(raw_wdata),
    .raddr(raw_raddr), .rdata(raw_rd)
  );

  hgbb_ram #(.WIDTH(NW), .DEPTH(MAX_CELLS)) u_cap (
    .clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
    .raddr(cap_raddr), .rdata(cap_rd)
  );

  hgbb_ram #(.WIDTH(SCW), .DEPTH(MAX_CELLS)) u_start (
    .clk(clk), .we(start_we), .waddr(start_waddr), .wdata(start_wdata),
    .raddr(start_raddr), .rdata(start_rd)
  );

  hgbb_ram #(.WIDTH(NW), .DEPTH(MAX_CELLS)) u_fill (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_rd)
  );

  hgbb_ram #(.WIDTH(48), .DEPTH(SORTED_DEPTH)) u_sorted (
    .clk(clk), .we(sort_we), .waddr(sort_waddr), .wdata(sort_wdata),
    .raddr(sort_raddr), .rdata(sort_rd)
  );

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign in_stall  = (state_r != hgbb_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign emit_ok   = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // result as it leaves, total taken from the last build
  always_comb begin
    emit_item              = res_r;
    emit_item.sorted_total = 14'(sorted_count_r);
  end

  // fresh result of an accepted beat; only a load can fail here
  always_comb begin
    res_init = '0;
    if (in_data.op == hgbb_pkg::OP_LOAD && 32'(raw_count_r) >= MAX_HITS) begin
      res_init.status = hgbb_pkg::STATUS_FULL;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared arithmetic
  // ---------------------------------------------------------------------------
  assign idx32   = 32'(in_data.read_index);
  assign cnt32   = 32'(cnt_r);
  assign base32  = 32'(base_r);
  assign w32     = 32'(w_r);
  assign h32     = 32'(h_r);
  assign run32   = 32'(run_r);
  assign cap32   = 32'(cap_rd);
  assign fill32  = 32'(fill_rd);
  assign start32 = 32'(start_rd);

  assign slot_ok = idx32 < 32'(sorted_count_r);
  assign cell_ok = idx32 < 32'(built_cells_r);

  // bin counts saturate to 1..62, phi further limited by the cell budget
  assign pe_clamp = (cfg.phi_bins == 6'd0) ? 6'd1 :
                    (32'(cfg.phi_bins) > hgbb_pkg::BINS_MAX) ? 6'(hgbb_pkg::BINS_MAX) :
                    cfg.phi_bins;
  assign te_clamp = (cfg.t_bins == 6'd0) ? 6'd1 :
                    (32'(cfg.t_bins) > hgbb_pkg::BINS_MAX) ? 6'(hgbb_pkg::BINS_MAX) :
                    cfg.t_bins;
  assign pe_lim   = (32'(pe_clamp) > PE_MAX) ? 6'(PE_MAX) : pe_clamp;
  assign lim_prod = (32'(te_r) + 32'd2) * w32;

  assign cell32 = 32'(bin_q) * w32 + 32'(ip_r);

  assign h_last     = (h32 + 32'd1) >= 32'(raw_count_r);
  assign row_last   = (32'(row_r) + 32'd1) >= 32'(hgt_r);
  assign clrs_last  = cnt32 == (SORTED_DEPTH - 1);
  assign cells_last = (cnt32 + 32'd1) >= 32'(cells_r);

  // running sum clip: a cell keeps what still fits in the sorted store
  assign room32 = SORTED_DEPTH - run32;
  assign clip32 = (cap32 > room32) ? room32 : cap32;

  // scatter slot
  assign scd32  = start32 + fill32;
  assign sc_put = fill32 < cap32;

  // border columns of the current row
  assign left_src32  = base32 + w32 - 32'd2;
  assign right_src32 = base32 + 32'd1;
  assign right_dst32 = base32 + w32 - 32'd1;
  assign src32 = side_r ? right_src32 : left_src32;
  assign dst32 = side_r ? right_dst32 : base32;

  assign n_min = (fsrc_r > cap_rd) ? cap_rd : fsrc_r;
  assign cps32 = 32'(sstart_r) + 32'(i_r);
  assign cpd32 = 32'(dstart_r) + 32'(i_r);
  assign cp_go = (i_r < n_r) && (cps32 < SORTED_DEPTH) && (cpd32 < SORTED_DEPTH);

  // seam wrap of a copied phi
  assign pbw18  = 18'(cfg.phi_bin_width);
  assign cp_phi = 18'(signed'(sort_rd[31:16]));
  always_comb begin
    cp_phi_w = cp_phi;
    if (!side_r) begin
      if (cp_phi > (18'(hgbb_pkg::PI_Q) - pbw18) && cp_phi > 18'sd0) begin
        cp_phi_w = cp_phi - 18'(hgbb_pkg::TWO_PI_Q);
      end
    end else begin
      if (cp_phi < (pbw18 - 18'(hgbb_pkg::PI_Q)) && cp_phi < 18'sd0) begin
        cp_phi_w = cp_phi + 18'(hgbb_pkg::TWO_PI_Q);
      end
    end
  end

  // bin unit operands: phi while the raw word is fresh, then t
  always_comb begin
    if (state_r == hgbb_pkg::S_HT) begin
      bin_diff = 18'(signed'(hit_r[15:0])) - 18'(cfg.t_minimum);
      bin_inv  = cfg.t_inverse_width;
      bin_nb   = te_r;
    end else begin
      bin_diff = 18'(signed'(raw_rd[31:16])) + 18'(hgbb_pkg::PI_Q);
      bin_inv  = cfg.phi_inverse_width;
      bin_nb   = pe_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hgbb_pkg::S_IDLE: begin
        if (in_accept) begin
          unique case (in_data.op)
            hgbb_pkg::OP_LOAD:      state_nxt = hgbb_pkg::S_EMIT;
            hgbb_pkg::OP_BUILD:     state_nxt = hgbb_pkg::S_SETUP;
            hgbb_pkg::OP_READ_SLOT: state_nxt = hgbb_pkg::S_RDS;
            hgbb_pkg::OP_READ_CELL: state_nxt = hgbb_pkg::S_RDC;
            default:                state_nxt = hgbb_pkg::S_EMIT;
          endcase
        end
      end
      hgbb_pkg::S_EMIT:  if (emit_ok) state_nxt = hgbb_pkg::S_IDLE;
      hgbb_pkg::S_RDS,
      hgbb_pkg::S_RDC:   state_nxt = hgbb_pkg::S_EMIT;
      hgbb_pkg::S_SETUP: state_nxt = hgbb_pkg::S_LIM;
      hgbb_pkg::S_LIM:   if (lim_prod <= MAX_CELLS) state_nxt = hgbb_pkg::S_CLRS;
      hgbb_pkg::S_CLRS:  if (clrs_last) state_nxt = hgbb_pkg::S_CLRC;
      hgbb_pkg::S_CLRC: begin
        if (cells_last) begin
          if (raw_count_r != '0)     state_nxt = hgbb_pkg::S_HRD;
          else if (cfg.clone_enable) state_nxt = hgbb_pkg::S_CC_RD;
          else                       state_nxt = hgbb_pkg::S_PF_RD;
        end
      end
      hgbb_pkg::S_HRD:   state_nxt = hgbb_pkg::S_HPHI;
      hgbb_pkg::S_HPHI:  state_nxt = hgbb_pkg::S_HT;
      hgbb_pkg::S_HT:    state_nxt = hgbb_pkg::S_HCELL;
      hgbb_pkg::S_HCELL: state_nxt = scat_r ? hgbb_pkg::S_SC_RD : hgbb_pkg::S_CNT_RD;
      hgbb_pkg::S_CNT_RD: state_nxt = hgbb_pkg::S_CNT_WR;
      hgbb_pkg::S_CNT_WR: begin
        if (!h_last)               state_nxt = hgbb_pkg::S_HRD;
        else if (cfg.clone_enable) state_nxt = hgbb_pkg::S_CC_RD;
        else                       state_nxt = hgbb_pkg::S_PF_RD;
      end
      hgbb_pkg::S_CC_RD: state_nxt = hgbb_pkg::S_CC_W1;
      hgbb_pkg::S_CC_W1: state_nxt = hgbb_pkg::S_CC_W2;
      hgbb_pkg::S_CC_W2: state_nxt = row_last ? hgbb_pkg::S_PF_RD : hgbb_pkg::S_CC_RD;
      hgbb_pkg::S_PF_RD: state_nxt = hgbb_pkg::S_PF_WR;
      hgbb_pkg::S_PF_WR: begin
        if (!cells_last)            state_nxt = hgbb_pkg::S_PF_RD;
        else if (raw_count_r != '0) state_nxt = hgbb_pkg::S_HRD;
        else if (cfg.clone_enable)  state_nxt = hgbb_pkg::S_CP_A;
        else                        state_nxt = hgbb_pkg::S_BDONE;
      end
      hgbb_pkg::S_SC_RD: state_nxt = hgbb_pkg::S_SC_WR;
      hgbb_pkg::S_SC_WR: begin
        if (!h_last)               state_nxt = hgbb_pkg::S_HRD;
        else if (cfg.clone_enable) state_nxt = hgbb_pkg::S_CP_A;
        else                       state_nxt = hgbb_pkg::S_BDONE;
      end
      hgbb_pkg::S_CP_A:  state_nxt = hgbb_pkg::S_CP_B;
      hgbb_pkg::S_CP_B:  state_nxt = hgbb_pkg::S_CP_C;
      hgbb_pkg::S_CP_C:  state_nxt = hgbb_pkg::S_CP_LOOP;
      hgbb_pkg::S_CP_LOOP: begin
        if (cp_go)                   state_nxt = hgbb_pkg::S_CP_W;
        else if (side_r && row_last) state_nxt = hgbb_pkg::S_BDONE;
        else                         state_nxt = hgbb_pkg::S_CP_A;
      end
      hgbb_pkg::S_CP_W:  state_nxt = hgbb_pkg::S_CP_LOOP;
      hgbb_pkg::S_BDONE: state_nxt = hgbb_pkg::S_EMIT;
      default:           state_nxt = hgbb_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Store controls
  // ---------------------------------------------------------------------------
  assign raw_we    = in_accept && (in_data.op == hgbb_pkg::OP_LOAD) &&
                     (32'(raw_count_r) < MAX_HITS);
  assign raw_wdata = {in_data.hit_id, in_data.hit_phi, in_data.hit_t};
  assign raw_raddr = h_r[HAW-1:0];

  always_comb begin
    cap_we      = 1'b0;
    cap_waddr   = cell_r;
    cap_wdata   = '0;
    cap_raddr   = cell_r;
    start_we    = 1'b0;
    start_waddr = cnt32[CAW-1:0];
    start_wdata = run_r;
    start_raddr = cell_r;
    fill_we     = 1'b0;
    fill_waddr  = cell_r;
    fill_wdata  = '0;
    fill_raddr  = cell_r;
    sort_we     = 1'b0;
    sort_waddr  = cnt32[SAW-1:0];
    sort_wdata  = '0;
    sort_raddr  = idx32[SAW-1:0];
    unique case (state_r)
      hgbb_pkg::S_IDLE: begin
        start_raddr = idx32[CAW-1:0];
        fill_raddr  = idx32[CAW-1:0];
      end
      hgbb_pkg::S_CLRS: begin
        sort_we = 1'b1;
      end
      hgbb_pkg::S_CLRC: begin
        cap_we    = 1'b1;
        cap_waddr = cnt32[CAW-1:0];
      end
      hgbb_pkg::S_CNT_WR: begin
        cap_we    = 1'b1;
        cap_wdata = cap_rd + NW'(1);
      end
      hgbb_pkg::S_CC_RD: begin
        cap_raddr = left_src32[CAW-1:0];
      end
      hgbb_pkg::S_CC_W1: begin
        cap_we    = 1'b1;
        cap_waddr = base32[CAW-1:0];
        cap_wdata = cap_rd;
        cap_raddr = right_src32[CAW-1:0];
      end
      hgbb_pkg::S_CC_W2: begin
        cap_we    = 1'b1;
        cap_waddr = right_dst32[CAW-1:0];
        cap_wdata = cap_rd;
      end
      hgbb_pkg::S_PF_RD: begin
        cap_raddr = cnt32[CAW-1:0];
      end
      hgbb_pkg::S_PF_WR: begin
        cap_we     = 1'b1;
        cap_waddr  = cnt32[CAW-1:0];
        cap_wdata  = NW'(clip32);
        start_we   = 1'b1;
        fill_we    = 1'b1;
        fill_waddr = cnt32[CAW-1:0];
      end
      hgbb_pkg::S_SC_WR: begin
        fill_we    = sc_put;
        fill_wdata = fill_rd + NW'(1);
        sort_we    = sc_put && (scd32 < SORTED_DEPTH);
        sort_waddr = scd32[SAW-1:0];
        sort_wdata = hit_r;
      end
      hgbb_pkg::S_CP_A: begin
        start_raddr = src32[CAW-1:0];
        fill_raddr  = src32[CAW-1:0];
      end
      hgbb_pkg::S_CP_B: begin
        start_raddr = dst32[CAW-1:0];
        cap_raddr   = dst32[CAW-1:0];
      end
      hgbb_pkg::S_CP_C: begin
        fill_we    = 1'b1;
        fill_waddr = dst32[CAW-1:0];
        fill_wdata = n_min;
      end
      hgbb_pkg::S_CP_LOOP: begin
        sort_raddr = cps32[SAW-1:0];
      end
      hgbb_pkg::S_CP_W: begin
        sort_we    = 1'b1;
        sort_waddr = cpd32[SAW-1:0];
        sort_wdata = {sort_rd[47:32], cp_phi_w[15:0], sort_rd[15:0]};
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= hgbb_pkg::S_IDLE;
      raw_count_r    <= '0;
      sorted_count_r <= '0;
      built_cells_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (raw_we) begin
        raw_count_r <= raw_count_r + HCW'(1);
      end
      if (state_r == hgbb_pkg::S_BDONE) begin
        sorted_count_r <= run_r;
        built_cells_r  <= cells_r;
      end
      if (state_r == hgbb_pkg::S_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == hgbb_pkg::S_EMIT && emit_ok) begin
      out_data_r <= emit_item;
    end
    case (state_r)
      hgbb_pkg::S_IDLE: begin
        if (in_accept) begin
          res_r    <= res_init;
          idx_ok_r <= (in_data.op == hgbb_pkg::OP_READ_SLOT) ? slot_ok : cell_ok;
        end
      end
      hgbb_pkg::S_RDS: begin
        if (idx_ok_r) begin
          res_r.out_id  <= sort_rd[47:32];
          res_r.out_phi <= sort_rd[31:16];
          res_r.out_t   <= sort_rd[15:0];
        end else begin
          res_r.status <= hgbb_pkg::STATUS_RANGE;
        end
      end
      hgbb_pkg::S_RDC: begin
        if (idx_ok_r) begin
          res_r.cell_first <= start32[12:0];
          res_r.cell_count <= fill32[12:0];
        end else begin
          res_r.status <= hgbb_pkg::STATUS_RANGE;
        end
      end
      hgbb_pkg::S_SETUP: begin
        pe_r <= pe_lim;
        te_r <= te_clamp;
        w_r  <= 7'(pe_lim) + 7'd2;
      end
      hgbb_pkg::S_LIM: begin
        // one step of t reduction per cycle until the grid fits
        if (lim_prod > MAX_CELLS) begin
          te_r <= te_r - 6'd1;
        end else begin
          hgt_r   <= 7'(te_r) + 7'd2;
          cells_r <= CCW'(lim_prod);
          cnt_r   <= '0;
        end
      end
      hgbb_pkg::S_CLRS: begin
        cnt_r <= clrs_last ? '0 : cnt_r + KW'(1);
      end
      hgbb_pkg::S_CLRC: begin
        cnt_r  <= cells_last ? '0 : cnt_r + KW'(1);
        h_r    <= '0;
        scat_r <= 1'b0;
        row_r  <= '0;
        base_r <= '0;
        side_r <= 1'b0;
        run_r  <= '0;
      end
      hgbb_pkg::S_HPHI:  hit_r  <= raw_rd;
      hgbb_pkg::S_HT:    ip_r   <= bin_q;
      hgbb_pkg::S_HCELL: cell_r <= cell32[CAW-1:0];
      hgbb_pkg::S_CNT_WR: begin
        h_r <= h_last ? '0 : h_r + HCW'(1);
      end
      hgbb_pkg::S_CC_W2: begin
        if (row_last) begin
          row_r  <= '0;
          base_r <= '0;
        end else begin
          row_r  <= row_r + 7'd1;
          base_r <= base_r + CCW'(w_r);
        end
      end
      hgbb_pkg::S_PF_WR: begin
        run_r <= run_r + SCW'(clip32);
        cnt_r <= cnt_r + KW'(1);
        if (cells_last) begin
          scat_r <= 1'b1;
          h_r    <= '0;
        end
      end
      hgbb_pkg::S_SC_WR: h_r <= h_r + HCW'(1);
      hgbb_pkg::S_CP_B: begin
        fsrc_r   <= fill_rd;
        sstart_r <= start_rd;
      end
      hgbb_pkg::S_CP_C: begin
        dstart_r <= start_rd;
        n_r      <= n_min;
        i_r      <= '0;
      end
      hgbb_pkg::S_CP_LOOP: begin
        if (!cp_go) begin
          if (!side_r) begin
            side_r <= 1'b1;
          end else begin
            side_r <= 1'b0;
            row_r  <= row_r + 7'd1;
            base_r <= base_r + CCW'(w_r);
          end
        end
      end
      hgbb_pkg::S_CP_W: i_r <= i_r + NW'(1);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_raw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(raw_count_r) <= MAX_HITS)
    else $error("raw hit count past store depth");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.op == hgbb_pkg::OP_LOAD && 32'(raw_count_r) < MAX_HITS)
    |=> (raw_count_r == $past(raw_count_r) + HCW'(1)))
    else $error("accepted load did not advance raw count");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hgbb_pkg::S_EMIT && out_valid_r && out_stall)
    |=> (state_r == hgbb_pkg::S_EMIT && $stable(out_data_r)))
    else $error("pending result overwritten");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hgbb_pkg::S_BDONE) |-> (32'(run_r) <= SORTED_DEPTH))
    else $error("sorted total past store depth");

endmodule

>>> rtl/hgbb_ram.sv
// Generic single write, single read RAM with registered read data.
module hgbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/hgbb_bin_unit.sv
// Shared bin unit: 1 + floor(diff * inv / 2^24), clamped to 1..nb, registered.
module hgbb_bin_unit (
  input  logic               clk,
  input  logic signed [17:0] diff,
  input  logic [23:0]        inv,
  input  logic [5:0]         nb,
  output logic [5:0]         bin_q
);

  logic [39:0] prod;
  logic [15:0] quo;
  logic [5:0]  bin_nxt;

  // positive diff always fits 16 bits
  assign prod = diff[15:0] * inv;
  assign quo  = prod[39:24];

  always_comb begin
    if (diff <= 18'sd0) begin
      bin_nxt = 6'd1;
    end else if (quo >= {10'd0, nb}) begin
      bin_nxt = nb;
    end else begin
      bin_nxt = quo[5:0] + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    bin_q <= bin_nxt;
  end

endmodule

>>> rtl/hgbb_regs.sv
// APB-style configuration registers of the bucket builder.
module hgbb_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output hgbb_pkg::cfg_t     cfg
);

  hgbb_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phi_bins          <= 6'd1;
      cfg_r.t_bins            <= 6'd1;
      cfg_r.t_minimum         <= 16'sd0;
      cfg_r.t_inverse_width   <= 24'd4096;
      cfg_r.phi_inverse_width <= 24'd4096;
      cfg_r.phi_bin_width     <= 15'd25736;
      cfg_r.clone_enable      <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        hgbb_pkg::REG_PHI_BINS:  cfg_r.phi_bins          <= pwdata[5:0];
        hgbb_pkg::REG_T_BINS:    cfg_r.t_bins            <= pwdata[5:0];
        hgbb_pkg::REG_T_MINIMUM: cfg_r.t_minimum         <= pwdata[15:0];
        hgbb_pkg::REG_T_INV:     cfg_r.t_inverse_width   <= pwdata[23:0];
        hgbb_pkg::REG_PHI_INV:   cfg_r.phi_inverse_width <= pwdata[23:0];
        hgbb_pkg::REG_PHI_BW:    cfg_r.phi_bin_width     <= pwdata[14:0];
        hgbb_pkg::REG_CLONE:     cfg_r.clone_enable      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (idx)
      hgbb_pkg::REG_PHI_BINS:  prdata = {26'd0, cfg_r.phi_bins};
      hgbb_pkg::REG_T_BINS:    prdata = {26'd0, cfg_r.t_bins};
      hgbb_pkg::REG_T_MINIMUM: prdata = {16'd0, cfg_r.t_minimum};
      hgbb_pkg::REG_T_INV:     prdata = {8'd0, cfg_r.t_inverse_width};
      hgbb_pkg::REG_PHI_INV:   prdata = {8'd0, cfg_r.phi_inverse_width};
      hgbb_pkg::REG_PHI_BW:    prdata = {17'd0, cfg_r.phi_bin_width};
      hgbb_pkg::REG_CLONE:     prdata = {31'd0, cfg_r.clone_enable};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule
